// ===== rtl/ips_pkg.sv =====
// Types, codes and constants shared by the IPS patch stream parser and its checker.
`default_nettype none

package ips_pkg;

    typedef enum logic [2:0]
    {
        PH_HEADER,
        PH_OFFSET,
        PH_LENGTH,
        PH_DATA,
        PH_RLE_COUNT,
        PH_RLE_VALUE,
        PH_DONE
    } ips_phase_t;

    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_TRUNC      = 3'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [2:0]  HEADER_LAST_IDX = 3'd4;
    localparam logic [23:0] EOF_MARK        = 24'h454F46;
    localparam logic [24:0] TARGET_SIZE_RST = 25'h1000000;

    typedef struct packed
    {
        logic [7:0] patch_byte;
        logic       first_byte;
        logic       last_byte;
    } ips_in_t;

    typedef struct packed
    {
        logic [1:0]  write_kind;
        logic [23:0] target_address;
        logic [7:0]  write_value;
        logic [15:0] fill_length;
        logic [2:0]  parse_status;
    } ips_out_t;

    function automatic logic [7:0] header_magic(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h50;
            3'd1:    ch = 8'h41;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h43;
            3'd4:    ch = 8'h48;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ips_patch_stream_parser.sv =====
// IPS patch stream parser: turns patch file bytes into byte write and fill commands.
//
//   channel | direction | handshake                    | payload
//   patch   | in        | patch_valid / patch_stall    | patch (ips_in_t)
//   cmd     | out       | cmd_valid / cmd_stall        | cmd (ips_out_t)
//   cfg     | in        | cfg_wr_en                    | cfg_wr_data (target_size)
//
// One item per cycle while patch_stall is low; each patch byte gives exactly one cmd
// item, registered when the byte is taken. The parse state and the result settle in
// the cycle the byte is taken; the cmd register holds the result until it is taken.
// Reset sets target_size to 2^24 and the parser to the header phase.
// patch_stall is high only while a result waits in the cmd register under cmd_stall.
`default_nettype none

module ips_patch_stream_parser
    import ips_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        patch_valid,
    output logic             patch_stall,
    input  wire ips_in_t     patch,
    output logic             cmd_valid,
    input  wire logic        cmd_stall,
    output ips_out_t         cmd,
    input  wire logic        cfg_wr_en,
    input  wire logic [24:0] cfg_wr_data
);

    logic [24:0] size_reg;

    ips_phase_t  phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [23:0] off_reg, off_next;
    logic [15:0] len_reg, len_next;
    logic [23:0] wp_reg, wp_next;
    logic [15:0] rem_reg, rem_next;
    logic [2:0]  status_reg, status_next;

    logic        cmd_valid_reg;
    ips_out_t    cmd_reg, cmd_next;

    ips_phase_t  ph_eff;
    logic [2:0]  cnt_eff;
    logic [23:0] off_eff, wp_eff;
    logic [15:0] len_eff, rem_eff, len_shift, rem_dec;
    logic [23:0] off_shift;
    logic [24:0] range_sum;
    logic        over;
    logic        take;

    assign patch_stall = cmd_valid_reg && cmd_stall;
    assign take        = patch_valid && !patch_stall;
    assign cmd_valid   = cmd_valid_reg;
    assign cmd         = cmd_reg;

    always_comb
    begin
        ph_eff  = patch.first_byte ? PH_HEADER  : phase_reg;
        cnt_eff = patch.first_byte ? 3'd0       : cnt_reg;
        off_eff = patch.first_byte ? 24'd0      : off_reg;
        len_eff = patch.first_byte ? 16'd0      : len_reg;
        wp_eff  = patch.first_byte ? 24'd0      : wp_reg;
        rem_eff = patch.first_byte ? 16'd0      : rem_reg;

        off_shift = {off_eff[15:0], patch.patch_byte};
        len_shift = {len_eff[7:0], patch.patch_byte};
        rem_dec   = rem_eff - 16'd1;
        range_sum = {1'b0, off_eff} + {9'd0, len_shift};
        over      = range_sum > size_reg;

        phase_next  = ph_eff;
        cnt_next    = cnt_eff;
        off_next    = off_eff;
        len_next    = len_eff;
        wp_next     = wp_eff;
        rem_next    = rem_eff;
        status_next = patch.first_byte ? ST_RUNNING : status_reg;
        cmd_next    = '0;

        unique case (ph_eff)
            PH_HEADER:
            begin
                if (cnt_eff > HEADER_LAST_IDX ||
                    patch.patch_byte != header_magic(cnt_eff))
                begin
                    status_next = ST_BAD_HEADER;
                    phase_next  = PH_DONE;
                end
                else if (cnt_eff == HEADER_LAST_IDX)
                begin
                    cnt_next   = 3'd0;
                    off_next   = 24'd0;
                    phase_next = PH_OFFSET;
                end
                else
                begin
                    cnt_next = cnt_eff + 3'd1;
                end
            end
            PH_OFFSET:
            begin
                off_next = off_shift;
                cnt_next = cnt_eff + 3'd1;
                if (cnt_eff >= 3'd2)
                begin
                    cnt_next = 3'd0;
                    if (off_shift == EOF_MARK)
                    begin
                        status_next = ST_OK;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        len_next   = 16'd0;
                        phase_next = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH:
            begin
                len_next = len_shift;
                cnt_next = cnt_eff + 3'd1;
                if (cnt_eff >= 3'd1)
                begin
                    cnt_next = 3'd0;
                    if (len_shift == 16'd0)
                    begin
                        phase_next = PH_RLE_COUNT;
                    end
                    else if (over)
                    begin
                        status_next = ST_RANGE;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        wp_next    = off_eff;
                        rem_next   = len_shift;
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                cmd_next.write_kind     = KIND_WRITE;
                cmd_next.target_address = wp_eff;
                cmd_next.write_value    = patch.patch_byte;
                wp_next                 = wp_eff + 24'd1;
                rem_next                = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    off_next   = 24'd0;
                    phase_next = PH_OFFSET;
                end
            end
            PH_RLE_COUNT:
            begin
                len_next = len_shift;
                cnt_next = cnt_eff + 3'd1;
                if (cnt_eff >= 3'd1)
                begin
                    cnt_next = 3'd0;
                    if (over)
                    begin
                        status_next = ST_RANGE;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_RLE_VALUE;
                    end
                end
            end
            PH_RLE_VALUE:
            begin
                if (len_eff != 16'd0)
                begin
                    cmd_next.write_kind     = KIND_FILL;
                    cmd_next.target_address = off_eff;
                    cmd_next.write_value    = patch.patch_byte;
                    cmd_next.fill_length    = len_eff;
                end
                off_next   = 24'd0;
                phase_next = PH_OFFSET;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (patch.last_byte && status_next == ST_RUNNING)
        begin
            status_next = (phase_next == PH_HEADER) ? ST_BAD_HEADER : ST_TRUNC;
            phase_next  = PH_DONE;
        end

        cmd_next.parse_status = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= TARGET_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            cnt_reg    <= 3'd0;
            off_reg    <= 24'd0;
            len_reg    <= 16'd0;
            wp_reg     <= 24'd0;
            rem_reg    <= 16'd0;
            status_reg <= ST_RUNNING;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            off_reg    <= off_next;
            len_reg    <= len_next;
            wp_reg     <= wp_next;
            rem_reg    <= rem_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ips_checker.sv =====
// Port-level checks for the IPS patch stream parser, bound to the top level.
`default_nettype none

module ips_checker
    import ips_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        patch_valid,
    input wire logic        patch_stall,
    input wire ips_in_t     patch,
    input wire logic        cmd_valid,
    input wire logic        cmd_stall,
    input wire ips_out_t    cmd,
    input wire logic        cfg_wr_en,
    input wire logic [24:0] cfg_wr_data
);

    logic unused_ok;
    assign unused_ok = ^{patch, cfg_wr_en, cfg_wr_data};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("cmd item changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        patch_stall |-> cmd_valid && cmd_stall)
        else $error("patch stalled without a waiting cmd item");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && !patch_stall |=> cmd_valid)
        else $error("accepted patch item gave no cmd item");

    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.write_kind != KIND_NONE |->
            cmd.parse_status == ST_RUNNING || cmd.parse_status == ST_TRUNC)
        else $error("write or fill issued with a final status");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.write_kind == KIND_NONE |->
            cmd.target_address == 24'd0 && cmd.write_value == 8'd0 &&
            cmd.fill_length == 16'd0)
        else $error("no-action item carries nonzero fields");

endmodule

bind ips_patch_stream_parser ips_checker u_ips_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .patch_valid (patch_valid),
    .patch_stall (patch_stall),
    .patch       (patch),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);

`default_nettype wire

// ===== tb/sv/ips_patch_stream_parser_test.sv =====
// Self-checking testbench for the IPS patch stream parser: directed table, random patch files.
`timescale 1ns / 100ps

module ips_patch_stream_parser_test;
    import ips_pkg::*;

    localparam logic [39:0] PATCH_MAGIC   = "PATCH";
    localparam int          HOLD_CYCLES   = 60;
    localparam int          PHASE_ITEMS   = 292;
    localparam ips_out_t    IDLE_RUN      = {KIND_NONE, 24'd0, 8'd0, 16'd0, ST_RUNNING};

    typedef enum logic [1:0]
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed
    {
        ips_in_t  item;
        logic     typed;
        ips_out_t cmd;
    } dir_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        patch_valid = 1'b0;
    logic        patch_stall;
    ips_in_t     patch       = '0;
    logic        cmd_valid;
    logic        cmd_stall   = 1'b0;
    ips_out_t    cmd;
    logic        cfg_wr_en   = 1'b0;
    logic [24:0] cfg_wr_data = '0;

    ips_phase_t  prs_phase     = PH_HEADER;
    logic [2:0]  prs_count     = '0;
    logic [23:0] prs_offset    = '0;
    logic [15:0] prs_length    = '0;
    logic [23:0] prs_pointer   = '0;
    logic [15:0] prs_remaining = '0;
    logic [2:0]  prs_status    = ST_RUNNING;
    logic [24:0] region_size   = TARGET_SIZE_RST;

    ips_out_t    expected_cmds [$];
    ips_out_t    oldest_cmd;
    ips_in_t     patch_file [$];
    idle_mode_t  idle_mode     = IDLE_NONE;
    int          mismatches    = 0;
    int          phase_items   = 0;
    int          byte_count    = 0;
    int          file_count    = 0;
    int          write_count   = 0;
    int          fill_count    = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    dir_row_t dir_rows [0:31] = '{
        {8'h50, 1'b0, 1'b0, 1'b1, IDLE_RUN},
        {8'h41, 1'b0, 1'b0, 1'b1, IDLE_RUN},
        {8'h54, 1'b0, 1'b0, 1'b1, IDLE_RUN},
        {8'h43, 1'b0, 1'b0, 1'b1, IDLE_RUN},
        {8'h48, 1'b0, 1'b0, 1'b1, IDLE_RUN},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h01, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hA5, 1'b0, 1'b0, 1'b1, KIND_WRITE, 24'hFFFFFF, 8'hA5, 16'd0, ST_RUNNING},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hFF, 1'b0, 1'b0, 1'b1, KIND_NONE, 24'd0, 8'd0, 16'd0, ST_RANGE},
        {8'h58, 1'b1, 1'b0, 1'b1, KIND_NONE, 24'd0, 8'd0, 16'd0, ST_BAD_HEADER},
        {8'h50, 1'b0, 1'b0, 1'b1, KIND_NONE, 24'd0, 8'd0, 16'd0, ST_BAD_HEADER},
        {8'h50, 1'b1, 1'b1, 1'b1, KIND_NONE, 24'd0, 8'd0, 16'd0, ST_BAD_HEADER},
        {8'h50, 1'b1, 1'b0, 1'b0, 53'd0},
        {8'h41, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h54, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h43, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h48, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'h00, 1'b0, 1'b0, 1'b0, 53'd0},
        {8'hC3, 1'b0, 1'b1, 1'b1, KIND_NONE, 24'd0, 8'd0, 16'd0, ST_TRUNC}
    };

    ips_patch_stream_parser u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .patch_valid (patch_valid),
        .patch_stall (patch_stall),
        .patch       (patch),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic ips_out_t advance_parser(input ips_in_t it);
        ips_out_t    res;
        logic [25:0] span_end;
        res = '0;
        if (it.first_byte)
        begin
            prs_phase     = PH_HEADER;
            prs_count     = '0;
            prs_offset    = '0;
            prs_length    = '0;
            prs_pointer   = '0;
            prs_remaining = '0;
            prs_status    = ST_RUNNING;
        end
        case (prs_phase)
            PH_HEADER:
            begin
                if (prs_count > HEADER_LAST_IDX ||
                    it.patch_byte != PATCH_MAGIC[8 * (HEADER_LAST_IDX - prs_count) +: 8])
                begin
                    prs_status = ST_BAD_HEADER;
                    prs_phase  = PH_DONE;
                end
                else if (prs_count == HEADER_LAST_IDX)
                begin
                    prs_count  = '0;
                    prs_offset = '0;
                    prs_phase  = PH_OFFSET;
                end
                else
                    prs_count++;
            end
            PH_OFFSET:
            begin
                prs_offset = {prs_offset[15:0], it.patch_byte};
                prs_count++;
                if (prs_count >= 3'd3)
                begin
                    prs_count = '0;
                    if (prs_offset == EOF_MARK)
                    begin
                        prs_status = ST_OK;
                        prs_phase  = PH_DONE;
                    end
                    else
                    begin
                        prs_length = '0;
                        prs_phase  = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH, PH_RLE_COUNT:
            begin
                prs_length = {prs_length[7:0], it.patch_byte};
                prs_count++;
                if (prs_count >= 3'd2)
                begin
                    prs_count = '0;
                    span_end  = {2'd0, prs_offset} + {10'd0, prs_length};
                    if (prs_phase == PH_LENGTH && prs_length == '0)
                        prs_phase = PH_RLE_COUNT;
                    else if (span_end > {1'b0, region_size})
                    begin
                        prs_status = ST_RANGE;
                        prs_phase  = PH_DONE;
                    end
                    else if (prs_phase == PH_RLE_COUNT)
                        prs_phase = PH_RLE_VALUE;
                    else
                    begin
                        prs_pointer   = prs_offset;
                        prs_remaining = prs_length;
                        prs_phase     = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                res.write_kind     = KIND_WRITE;
                res.target_address = prs_pointer;
                res.write_value    = it.patch_byte;
                prs_pointer++;
                prs_remaining--;
                if (prs_remaining == '0)
                begin
                    prs_offset = '0;
                    prs_phase  = PH_OFFSET;
                end
            end
            PH_RLE_VALUE:
            begin
                if (prs_length != '0)
                begin
                    res.write_kind     = KIND_FILL;
                    res.target_address = prs_offset;
                    res.write_value    = it.patch_byte;
                    res.fill_length    = prs_length;
                end
                prs_offset = '0;
                prs_phase  = PH_OFFSET;
            end
            default:
                prs_phase = PH_DONE;
        endcase
        if (it.last_byte && prs_status == ST_RUNNING)
        begin
            prs_status = (prs_phase == PH_HEADER) ? ST_BAD_HEADER : ST_TRUNC;
            prs_phase  = PH_DONE;
        end
        res.parse_status = prs_status;
        return res;
    endfunction

    function automatic logic roll_idle(input logic rx_side);
        int pct;
        pct = $urandom_range(0, 99);
        case (idle_mode)
            IDLE_SENDER:   return !rx_side && pct < 78;
            IDLE_RECEIVER: return rx_side && pct < 78;
            IDLE_BOTH:     return pct < 20;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic offer_byte(input ips_in_t it, input logic typed, input ips_out_t typed_cmd);
        ips_out_t predicted;
        while (roll_idle(1'b0))
        begin
            patch_valid <= 1'b0;
            @(negedge clk);
        end
        patch_valid <= 1'b1;
        patch       <= it;
        @(posedge clk);
        while (patch_stall)
            @(posedge clk);
        predicted = advance_parser(it);
        expected_cmds.push_back(typed ? typed_cmd : predicted);
        phase_items += 1;
        byte_count  += 1;
        write_count += int'(predicted.write_kind == KIND_WRITE);
        fill_count  += int'(predicted.write_kind == KIND_FILL);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        patch_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        patch_file.push_back({b, 1'b0, 1'b0});
    endtask

    task automatic add_record();
        int unsigned len;
        int unsigned off;
        logic        rle;
        rle = $urandom_range(0, 99) < 30;
        if (rle)
            case ($urandom_range(0, 3))
                0:       len = 0;
                1:       len = $urandom_range(1, 16);
                2:       len = 65535;
                default: len = $urandom_range(1, 65535);
            endcase
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(1, 8);
        if (region_size < len || $urandom_range(0, 9) == 0)
            off = $urandom_range(0, 24'hFFFFFF);
        else
            off = $urandom_range(0, region_size - len) & 24'hFFFFFF;
        put_byte(off[23:16]);
        put_byte(off[15:8]);
        put_byte(off[7:0]);
        if (rle)
        begin
            put_byte(8'h00);
            put_byte(8'h00);
        end
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        if (rle)
            put_byte(8'($urandom_range(0, 255)));
        else
            repeat (len) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_file();
        int shape;
        int cut;
        patch_file.delete();
        shape = $urandom_range(0, 99);
        if (shape < 90)
        begin
            for (int i = 0; i < 5; i++)
                put_byte(PATCH_MAGIC[8 * (4 - i) +: 8]);
            if (shape >= 80)
            begin
                patch_file[$urandom_range(0, 4)].patch_byte = 8'($urandom_range(0, 255));
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 5)) add_record();
                put_byte(EOF_MARK[23:16]);
                put_byte(EOF_MARK[15:8]);
                put_byte(EOF_MARK[7:0]);
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
                if (shape >= 65)
                begin
                    cut = $urandom_range(1, patch_file.size() - 1);
                    while (patch_file.size() > cut)
                        void'(patch_file.pop_back());
                end
            end
            patch_file[0].first_byte = 1'b1;
            if ($urandom_range(0, 9) != 0)
                patch_file[patch_file.size() - 1].last_byte = 1'b1;
        end
        else
        begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
            foreach (patch_file[i])
            begin
                patch_file[i].first_byte = $urandom_range(0, 3) == 0;
                patch_file[i].last_byte  = $urandom_range(0, 3) == 0;
            end
        end
        file_count++;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            cmd_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            cmd_stall   <= 1'b1;
        end
        else
            cmd_stall <= roll_idle(1'b1);
    end

    task automatic note_mismatch(input string what, input ips_out_t want, input ips_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected kind %0d addr %h value %h len %h status %0d, %s",
                     what, want.write_kind, want.target_address, want.write_value,
                     want.fill_length, want.parse_status,
                     $sformatf("got kind %0d addr %h value %h len %h status %0d",
                               got.write_kind, got.target_address, got.write_value,
                               got.fill_length, got.parse_status));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (expected_cmds.size() == 0)
                note_mismatch("cmd item with none pending", '0, cmd);
            else
            begin
                oldest_cmd = expected_cmds.pop_front();
                if (oldest_cmd.write_kind !== cmd.write_kind ||
                    oldest_cmd.target_address !== cmd.target_address ||
                    oldest_cmd.write_value !== cmd.write_value ||
                    oldest_cmd.fill_length !== cmd.fill_length ||
                    oldest_cmd.parse_status !== cmd.parse_status)
                    note_mismatch("cmd item mismatch", oldest_cmd, cmd);
            end
        end
    end

    initial
    begin
        #400000;
        $display("ips_patch_stream_parser_test: errors");
        $finish;
    end

    initial
    begin
        logic [24:0] size_now;
        idle_mode_t  mode_now;
        logic        paused;
        paused = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].cmd);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    size_now = TARGET_SIZE_RST;
                    mode_now = IDLE_NONE;
                end
                1:
                begin
                    size_now = '0;
                    mode_now = IDLE_SENDER;
                end
                2:
                begin
                    size_now = 25'($urandom_range(16, 600));
                    mode_now = IDLE_RECEIVER;
                end
                3:
                begin
                    size_now = TARGET_SIZE_RST;
                    mode_now = IDLE_BOTH;
                end
                4:
                begin
                    size_now = 25'($urandom_range(0, TARGET_SIZE_RST));
                    mode_now = IDLE_NONE;
                end
                default:
                begin
                    size_now = 25'($urandom_range(1, 64));
                    mode_now = IDLE_BOTH;
                end
            endcase
            wait_drained();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= size_now;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            region_size = size_now;
            idle_mode   = mode_now;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (p == 2 && !paused && phase_items > PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if (p == 4 && hold_requests == 0 && phase_items > 100)
                    hold_requests++;
                build_file();
                foreach (patch_file[i])
                    offer_byte(patch_file[i], 1'b0, '0);
            end
        end
        wait_drained();

        $display("%0d patch bytes in %0d files: %0d byte writes and %0d fills predicted",
                 byte_count, file_count, write_count, fill_count);
        $display("region sizes from zero to full, steady, sender, receiver and mixed idling");
        if (mismatches == 0)
            $display("ips_patch_stream_parser_test: clean");
        else
            $display("ips_patch_stream_parser_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ips_pkg.sv
rtl/ips_patch_stream_parser.sv
rtl/ips_checker.sv
tb/sv/ips_patch_stream_parser_test.sv
